// ===== sv/phmt_pkg.sv =====
// shared types, constants and register indexes for the press hold minimum tracker
`default_nettype none

package phmt_pkg;

    localparam int SampleWidth  = 13;
    localparam int ReadingWidth = 10;
    localparam int CountWidth   = 8;
    localparam int CfgIdxWidth  = 2;

    // divide by ten as multiply by reciprocal, exact for 13 bit inputs
    localparam int             Div10Shift = 19;
    localparam logic [15:0]    Div10Mult  = 16'd52429;

    localparam logic [CountWidth-1:0]   LenTop       = 8'd240;
    localparam logic [CountWidth-1:0]   LenWrap      = 8'd201;
    localparam logic [CountWidth-1:0]   GapTop       = 8'd255;
    localparam logic [ReadingWidth-1:0] NoValue      = 10'd1023;
    localparam logic [2:0]              LiveEvery    = 3'd0;

    localparam logic [CountWidth-1:0]   SettleReset   = 8'd10;
    localparam logic [CountWidth-1:0]   ShortMaxReset = 8'd10;
    localparam logic [CountWidth-1:0]   GapMaxReset   = 8'd8;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SETTLE_TICKS    = 2'd0,
        CFG_SHORT_PRESS_MAX = 2'd1,
        CFG_DOUBLE_GAP_MAX  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                   key_pressed;
        logic [SampleWidth-1:0] sample_mv;
    } in_item_t;

    typedef struct packed {
        logic                    live_valid;
        logic [ReadingWidth-1:0] live_value;
        logic                    hold_update;
        logic                    hold_valid;
        logic [ReadingWidth-1:0] hold_value;
        logic                    finished;
    } out_item_t;

    typedef struct packed {
        logic [CountWidth-1:0] settle_ticks;
        logic [CountWidth-1:0] short_press_max;
        logic [CountWidth-1:0] double_gap_max;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/phmt_div10.sv =====
// millivolt sample to 0.01 volt reading, by reciprocal multiply
`default_nettype none

module phmt_div10 (
    input  wire logic [phmt_pkg::SampleWidth-1:0]  sample_mv,
    output logic      [phmt_pkg::ReadingWidth-1:0] reading
);

    localparam int ProdWidth = phmt_pkg::SampleWidth + 16;

    logic [ProdWidth-1:0] product;

    assign product = ProdWidth'(sample_mv) * ProdWidth'(phmt_pkg::Div10Mult);
    assign reading = product[phmt_pkg::Div10Shift +: phmt_pkg::ReadingWidth];

endmodule

`default_nettype wire

// ===== sv/phmt_track.sv =====
// press, gap and minimum tracking state with the per-tick result logic
`default_nettype none

module phmt_track (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire phmt_pkg::in_item_t  item,
    input  wire phmt_pkg::cfg_t      cfg,
    output phmt_pkg::out_item_t      result
);

    logic [phmt_pkg::CountWidth-1:0]   press_length_reg, press_length_next;
    logic [phmt_pkg::CountWidth-1:0]   gap_length_reg, gap_length_next;
    logic [phmt_pkg::ReadingWidth-1:0] minimum_reg, minimum_next;
    logic                              short_seen_reg, short_seen_next;
    logic                              done_reg, done_next;

    logic [phmt_pkg::ReadingWidth-1:0] reading;
    logic [phmt_pkg::CountWidth-1:0]   gap_inc;
    logic [phmt_pkg::CountWidth-1:0]   press_inc;

    phmt_div10 u_div10 (
        .sample_mv (item.sample_mv),
        .reading   (reading)
    );

    assign gap_inc   = (gap_length_reg == phmt_pkg::GapTop) ? gap_length_reg
                                                             : gap_length_reg + 8'd1;
    assign press_inc = (press_length_reg == phmt_pkg::LenTop) ? phmt_pkg::LenWrap
                                                               : press_length_reg + 8'd1;

    always_comb begin
        press_length_next = press_length_reg;
        gap_length_next   = gap_length_reg;
        minimum_next      = minimum_reg;
        short_seen_next   = short_seen_reg;
        done_next         = done_reg;
        result            = '0;

        if (!done_reg) begin
            if (item.key_pressed) begin
                if (press_length_reg[2:0] == phmt_pkg::LiveEvery) begin
                    result.live_valid = 1'b1;
                    result.live_value = reading;
                end
                if (press_length_reg == '0) begin
                    gap_length_next = gap_inc;
                    minimum_next    = phmt_pkg::NoValue;
                end else if (press_length_reg >= cfg.settle_ticks) begin
                    if (reading < minimum_reg) begin
                        minimum_next = reading;
                    end
                end
                press_length_next = press_inc;
            end else if (press_length_reg != '0) begin
                if (short_seen_reg) begin
                    if (gap_length_reg <= cfg.double_gap_max) begin
                        done_next = 1'b1;
                    end else begin
                        short_seen_next = 1'b0;
                    end
                end else if (press_length_reg <= cfg.short_press_max) begin
                    short_seen_next = 1'b1;
                end
                result.hold_update = 1'b1;
                if (minimum_reg != phmt_pkg::NoValue) begin
                    result.hold_valid = 1'b1;
                    result.hold_value = minimum_reg;
                end
                press_length_next = '0;
                gap_length_next   = '0;
            end else begin
                gap_length_next = gap_inc;
            end
        end

        result.finished = done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_length_reg <= '0;
            gap_length_reg   <= '0;
            minimum_reg      <= phmt_pkg::NoValue;
            short_seen_reg   <= 1'b0;
            done_reg         <= 1'b0;
        end else if (advance) begin
            press_length_reg <= press_length_next;
            gap_length_reg   <= gap_length_next;
            minimum_reg      <= minimum_next;
            short_seen_reg   <= short_seen_next;
            done_reg         <= done_next;
        end
    end

    // a finished session never reopens
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("session done flag cleared");

    // press length never runs past its top value
    a_press_range: assert property (@(posedge aclk) disable iff (!aresetn)
        press_length_reg <= phmt_pkg::LenTop)
        else $error("press length out of range");

    // a processed release clears both counters
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.hold_update |=> press_length_reg == '0 && gap_length_reg == '0)
        else $error("release did not clear counters");

    // state is frozen once the session is done
    a_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> $stable(press_length_reg) && $stable(minimum_reg))
        else $error("state moved after session end");

endmodule

`default_nettype wire

// ===== sv/press_hold_minimum_tracker.sv =====
// top level: config registers, input register, tracker and result register
`default_nettype none

// Press hold minimum tracker. Each request carries one tick: the button level
// and a divider voltage in mV. Every request yields exactly one result request
// with the live reading (0.01 V, shown every eighth pressed tick), the held
// minimum on the tick a release is processed, and the finished flag once a
// short press followed by a quick second press ends the session. The block
// takes one request per cycle while the result register is not stalled: the
// input register feeds the tracking logic (a 13x16 reciprocal multiply plus
// the counter compares), whose outcome lands in the result register when the
// item advances. The only stall is back-pressure from m_ready. The three
// configuration registers (settle ticks, short press maximum, double press
// gap) are written through cfg_wr_en/cfg_index/cfg_wdata and should only be
// changed while no request is in flight; an index past the last is ignored.
module press_hold_minimum_tracker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire phmt_pkg::in_item_t                 s_data,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output phmt_pkg::out_item_t                     m_data,

    input  wire logic                               cfg_wr_en,
    input  wire logic [phmt_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [phmt_pkg::CountWidth-1:0]    cfg_wdata
);

    // configuration
    phmt_pkg::cfg_t cfg_reg;

    // input stage
    logic               in_valid_reg;
    phmt_pkg::in_item_t in_data_reg;

    // result stage
    logic                out_valid_reg;
    phmt_pkg::out_item_t out_data_reg;
    phmt_pkg::out_item_t result;

    // the held item moves on when the result register is free or being drained
    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // config writes, out of range index dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks    <= phmt_pkg::SettleReset;
            cfg_reg.short_press_max <= phmt_pkg::ShortMaxReset;
            cfg_reg.double_gap_max  <= phmt_pkg::GapMaxReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                phmt_pkg::CFG_SETTLE_TICKS:    cfg_reg.settle_ticks    <= cfg_wdata;
                phmt_pkg::CFG_SHORT_PRESS_MAX: cfg_reg.short_press_max <= cfg_wdata;
                phmt_pkg::CFG_DOUBLE_GAP_MAX:  cfg_reg.double_gap_max  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register, reloads whenever it empties or passes its item on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    phmt_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // every tick request that advances yields a result request
    a_out_needs_in: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced item lost");

    // the input stage only empties by moving into the result register
    a_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("held tick request dropped");

    // a stalled result register keeps the tracker from advancing
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result overwritten under back-pressure");

endmodule

`default_nettype wire
